// ----- rtl/core/bfs_pkg.sv -----
// Shared types, constants and codes for the binary format sniffer.
package bfs_pkg;

  // Byte positions count up to this value and then hold.
  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Header bytes kept per file by default, and the bytes the classifier looks at.
  localparam int HEADER_BYTES_DEF = 28;
  localparam int CLS_BYTES = 28;

  // The tar signature sits at a fixed offset.
  localparam int TAR_OFFSET = 257;
  localparam int TAR_LEN = 5;

  // Queue of finished files between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration register indexes.
  localparam logic REG_RAW_MODE = 1'b0;
  localparam logic REG_MIN_COFF = 1'b1;

  localparam int COFF_W = 9;
  localparam logic [COFF_W-1:0] MIN_COFF_RESET = 9'd20;

  // "ustar", first character in element 0.
  localparam logic [TAR_LEN-1:0][7:0] USTAR_SIG = {8'h72, 8'h61, 8'h74, 8'h73, 8'h75};

  // Big object COFF signature at offset 12, first byte in element 0.
  localparam logic [15:0][7:0] BIGOBJ_SIG = {
    8'hb8, 8'hdc, 8'ha4, 8'h6a, 8'hf6, 8'hfa, 8'h20, 8'haf,
    8'h4b, 8'ha9, 8'hba, 8'hee, 8'hd1, 8'hba, 8'ha1, 8'hc7
  };

  // "PS-X EXE", first character in the low byte.
  localparam logic [63:0] PSX_SIG = 64'h4558_4520_582D_5350;

  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_PE      = 3'd1,
    FMT_ELF     = 3'd2,
    FMT_COFF    = 3'd3,
    FMT_MACHO   = 3'd4,
    FMT_IHEX    = 3'd5,
    FMT_RAW     = 3'd6
  } format_t;

  // One finished file handed from the front to the back.
  typedef struct packed {
    logic [CLS_BYTES-1:0][7:0] head;
    logic                      ustar;
    logic [POS_W-1:0]          length;
  } job_t;

endpackage

// ----- rtl/core/bfs_front.sv -----
// Front end: captures header and tar bytes, counts length, emits one job per file.
module bfs_front import bfs_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output job_t       job
);

  localparam int KEEP_BYTES = (HEADER_BYTES < CLS_BYTES) ? HEADER_BYTES : CLS_BYTES;

  logic [7:0]                header [KEEP_BYTES];
  logic [7:0]                tar_sig [TAR_LEN];
  logic [TAR_LEN-1:0][7:0]   tar_now;
  logic [POS_W-1:0]          byte_position;
  logic [POS_W-1:0]          byte_position_next;

  // The current byte is merged in so the last byte of a file is seen as well.
  for (genvar i = 0; i < CLS_BYTES; i++) begin : g_head
    if (i < KEEP_BYTES) begin : g_keep
      assign job.head[i] = (byte_position == POS_W'(i)) ? data_byte : header[i];
    end else begin : g_zero
      assign job.head[i] = 8'h00;
    end
  end

  for (genvar k = 0; k < TAR_LEN; k++) begin : g_tar
    assign tar_now[k] = (byte_position == POS_W'(TAR_OFFSET + k)) ? data_byte : tar_sig[k];
  end

  assign byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                         : byte_position + 1'b1;
  assign job.ustar  = (tar_now == USTAR_SIG);
  assign job.length = byte_position_next;
  assign push       = fire & last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      for (int i = 0; i < KEEP_BYTES; i++) header[i] <= 8'h00;
      for (int k = 0; k < TAR_LEN; k++) tar_sig[k] <= 8'h00;
    end else if (fire) begin
      if (last_byte) begin
        byte_position <= '0;
        for (int i = 0; i < KEEP_BYTES; i++) header[i] <= 8'h00;
        for (int k = 0; k < TAR_LEN; k++) tar_sig[k] <= 8'h00;
      end else begin
        byte_position <= byte_position_next;
        for (int i = 0; i < KEEP_BYTES; i++) header[i] <= job.head[i];
        for (int k = 0; k < TAR_LEN; k++) tar_sig[k] <= tar_now[k];
      end
    end
  end

endmodule

// ----- rtl/core/bfs_queue.sv -----
// Small job queue between the front end and the classifier.
module bfs_queue import bfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic not_full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign not_full  = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      priority if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      else count <= count;
    end
  end

endmodule

// ----- rtl/core/bfs_back.sv -----
// Back end: classifies one queued file and holds the code in the output register.
module bfs_back import bfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  job_t              job,
  output logic              pop,
  input  logic              raw_mode,
  input  logic [COFF_W-1:0] min_coff_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        format_code
);

  function automatic logic is_coff_machine(input logic [15:0] m);
    logic hit;
    unique case (m)
      16'h014c, 16'h014d, 16'h014e, 16'h0184, 16'h01a2, 16'h01a3, 16'h01a4,
      16'h01a6, 16'h01a8, 16'h01c0, 16'h01c2, 16'h01c4, 16'h01d3, 16'h01f0,
      16'h0200, 16'h0268, 16'h0290, 16'h0284, 16'h0160, 16'h0162, 16'h0163,
      16'h0166, 16'h0140, 16'h0142, 16'h0266, 16'h0168, 16'h0169, 16'h0366,
      16'h0466, 16'h0520, 16'h0ebc, 16'h8664, 16'h9041, 16'haa64,
      16'hc0ee: hit = 1'b1;
      default:  hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic format_t classify(input job_t j, input logic raw,
                                       input logic [COFF_W-1:0] min_coff);
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] be0;
    logic        macho;
    logic        odd_feedface;
    logic        java;
    format_t     coff_code;
    format_t     f;
    w0  = {j.head[3], j.head[2], j.head[1], j.head[0]};
    w1  = {j.head[7], j.head[6], j.head[5], j.head[4]};
    w2  = {j.head[11], j.head[10], j.head[9], j.head[8]};
    w3  = {j.head[15], j.head[14], j.head[13], j.head[12]};
    be0 = {j.head[0], j.head[1], j.head[2], j.head[3]};
    macho = (be0 == 32'hfeedface) || (be0 == 32'hfeedfacf) ||
            (be0 == 32'hcefaedfe) || (be0 == 32'hcffaedfe) ||
            (be0 == 32'hcafebabe);
    odd_feedface = (w0 == 32'hfeedface) && (w1 == 32'h10) && (w2 == 32'h2) &&
                   (w3 > 32'h10);
    java = ((w0 == 32'hcafebabe) || (w0 == 32'hbebafeca)) && (w1 > 32'd30);
    coff_code = ({1'b0, j.length} < {1'b0, min_coff}) ? FMT_UNKNOWN : FMT_COFF;
    priority if (raw) f = FMT_RAW;
    else if ((w0 == 32'h0064_0107) || (j.head[7:0] == PSX_SIG) || j.ustar)
      f = FMT_UNKNOWN;
    else if (({j.head[1], j.head[0]} == 16'h5a4d) || ({j.head[1], j.head[0]} == 16'h4d5a))
      f = FMT_PE;
    else if (w0 == 32'h464c_457f) f = FMT_ELF;
    else if (j.head[0] == 8'h3a) f = FMT_IHEX;
    else if (is_coff_machine({j.head[1], j.head[0]})) f = coff_code;
    else if (macho) f = (odd_feedface || java) ? FMT_UNKNOWN : FMT_MACHO;
    else if (j.head[27:12] == BIGOBJ_SIG) f = coff_code;
    else f = FMT_UNKNOWN;
    return f;
  endfunction

  format_t code;

  assign code = classify(job, raw_mode, min_coff_size);
  assign pop  = job_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) format_code <= code;
  end

endmodule

// ----- rtl/core/binary_format_sniffer_unit.sv -----
// Top level of the binary format sniffer: configuration registers and the three stages.
// Throughput is one file byte per cycle while the queue has room; a one-byte file may follow
// another in the next cycle. The job is written into the queue with the last byte, and the
// classifier's output register then presents the code once that output is free or being taken.
// Synchronous reset clears the file capture state, empties the queue and the output,
// and sets raw_mode to 0 and min_coff_size to 20; no clearing pass is needed.
module binary_format_sniffer_unit import bfs_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Byte stream of one file after another.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // One format code per file.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  format_code,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              raw_mode;
  logic [COFF_W-1:0] min_coff_size;
  logic              cfg_write;
  logic              in_fire;
  logic              push;
  job_t              push_job;
  logic              q_not_full;
  logic              pop;
  logic              pop_valid;
  job_t              pop_job;

  // Register index is the word address; the low two address bits select bytes
  // within a word and are not decoded.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_mode      <= 1'b0;
      min_coff_size <= MIN_COFF_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RAW_MODE: raw_mode      <= pwdata[0];
        REG_MIN_COFF: min_coff_size <= pwdata[COFF_W-1:0];
        default:      raw_mode      <= raw_mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RAW_MODE: prdata = {31'b0, raw_mode};
      REG_MIN_COFF: prdata = {{(32 - COFF_W){1'b0}}, min_coff_size};
      default:      prdata = '0;
    endcase
  end

  // The front stalls only when the queue holds two finished files that the
  // classifier has not yet been able to take; plain bytes then wait too, which
  // keeps the ready logic independent of the payload.
  assign in_ready = q_not_full;
  assign in_fire  = in_valid && in_ready;

  bfs_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .job       (push_job)
  );

  // The queue decouples the byte intake from a stalled output: files keep
  // streaming in while earlier codes wait for the consumer.
  bfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .not_full  (q_not_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  // The classifier evaluates the whole decision order combinationally and
  // registers the code; it takes a new job whenever its output is free or
  // being taken in the same cycle.
  bfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (pop_valid),
    .job           (pop_job),
    .pop           (pop),
    .raw_mode      (raw_mode),
    .min_coff_size (min_coff_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .format_code   (format_code)
  );

endmodule
